### rtl/core/rsm_pkg.sv
// ----------------------------------------------------------------------------
// rsm_pkg
// Shared constants, types and the exp mantissa factor table for the row
// softmax core.
// ----------------------------------------------------------------------------
package rsm_pkg;

   localparam int MAX_ROW        = 64;
   localparam int EXP_TABLE_BITS = 8;
   localparam int IDX_W          = $clog2(MAX_ROW);
   localparam int CNT_W          = $clog2(MAX_ROW + 1);
   localparam int LEN_W          = 7;
   localparam int SUM_W          = 24;
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_W    = 1;
   localparam logic [16:0] LOG2E_Q16 = 17'd94548;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic             tensor_end;
      logic [15:0]      row_max;
      logic             bank;
   } row_job_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXP,
      ST_DIV,
      ST_OUT
   } back_state_type;

   // f[i] = floor(sqrt(f[i-1] * 2^32)) starting at floor(sqrt(2^63))
   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bitv;
      logic [63:0] x;
      res  = '0;
      x    = v;
      bitv = 64'h4000_0000_0000_0000;
      for (int s = 0; s < 32; s++) begin
         if (bitv != 0) begin
            if (x >= res + bitv) begin
               x   = x - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
            bitv = bitv >> 2;
         end
      end
      return res;
   endfunction

   function automatic logic [63:0] exp_factor(input int idx);
      logic [63:0] f;
      f = isqrt64(64'h8000_0000_0000_0000);
      for (int i = 1; i < EXP_TABLE_BITS + 1; i++) begin
         if (i < idx) begin
            f = isqrt64(f << 32);
         end
      end
      return f;
   endfunction

endpackage

### rtl/core/rsm_front.sv
// ----------------------------------------------------------------------------
// rsm_front
// Accepts scores, writes them to the double-banked row buffer, tracks the
// running maximum and hands closed rows to the job queue.
// ----------------------------------------------------------------------------
module rsm_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [15:0]              req_score,
   input  logic                     req_last_in_tensor,
   input  logic [rsm_pkg::LEN_W-1:0] row_length_ff,
   input  logic                     job_full,
   input  logic [1:0]               bank_busy,
   output logic                     buf_we,
   output logic [rsm_pkg::IDX_W:0]  buf_waddr,
   output logic [15:0]              buf_wdata,
   output logic                     job_push,
   output rsm_pkg::row_job_type     job_data
);

   logic [rsm_pkg::CNT_W-1:0] fill_ff, fill_in;
   logic signed [15:0]        max_ff, max_in;
   logic                      bank_ff, bank_in;
   logic [rsm_pkg::CNT_W-1:0] len_eff;
   logic [rsm_pkg::CNT_W-1:0] count;
   logic [rsm_pkg::IDX_W-1:0] idx;
   logic signed [15:0]        new_max;
   logic                      close;
   logic                      acc;

   always_comb begin
      if (row_length_ff == '0) begin
         len_eff = rsm_pkg::CNT_W'(1);
      end else if (rsm_pkg::CNT_W'(row_length_ff) > rsm_pkg::CNT_W'(rsm_pkg::MAX_ROW)) begin
         len_eff = rsm_pkg::CNT_W'(rsm_pkg::MAX_ROW);
      end else begin
         len_eff = rsm_pkg::CNT_W'(row_length_ff);
      end
   end

   assign idx     = (fill_ff >= rsm_pkg::CNT_W'(rsm_pkg::MAX_ROW))
                  ? rsm_pkg::IDX_W'(rsm_pkg::MAX_ROW - 1) : fill_ff[rsm_pkg::IDX_W-1:0];
   assign count   = rsm_pkg::CNT_W'(idx) + rsm_pkg::CNT_W'(1);
   assign new_max = ($signed(req_score) > max_ff) ? $signed(req_score) : max_ff;
   assign close   = (count >= len_eff) || req_last_in_tensor;
   assign req_ready = !bank_busy[bank_ff] && !job_full;
   assign acc     = req_valid && req_ready;

   assign buf_we    = acc;
   assign buf_waddr = {bank_ff, idx};
   assign buf_wdata = req_score;
   assign job_push  = acc && close;
   assign job_data  = '{count: count, tensor_end: req_last_in_tensor,
                        row_max: new_max, bank: bank_ff};

   always_comb begin
      fill_in = fill_ff;
      max_in  = max_ff;
      bank_in = bank_ff;
      if (acc) begin
         if (close) begin
            fill_in = '0;
            max_in  = 16'sh8000;
            bank_in = !bank_ff;
         end else begin
            fill_in = count;
            max_in  = new_max;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         max_ff  <= 16'sh8000;
         bank_ff <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         max_ff  <= max_in;
         bank_ff <= bank_in;
      end
   end

endmodule

### rtl/core/rsm_queue.sv
// ----------------------------------------------------------------------------
// rsm_queue
// Short queue of closed-row jobs between the front and back parts.
// ----------------------------------------------------------------------------
module rsm_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  rsm_pkg::row_job_type push_data,
   output logic                 full,
   input  logic                 pop,
   output logic                 not_empty,
   output rsm_pkg::row_job_type head
);

   rsm_pkg::row_job_type            slot_ff [rsm_pkg::QUEUE_DEPTH];
   logic [rsm_pkg::QUEUE_PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [rsm_pkg::QUEUE_PTR_W:0]   cnt_ff, cnt_in;

   assign full      = cnt_ff == (rsm_pkg::QUEUE_PTR_W+1)'(rsm_pkg::QUEUE_DEPTH);
   assign not_empty = cnt_ff != '0;
   assign head      = slot_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (rsm_pkg::QUEUE_PTR_W+1)'(push) - (rsm_pkg::QUEUE_PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

### rtl/core/rsm_back.sv
// ----------------------------------------------------------------------------
// rsm_back
// Runs one row job: exp pass with a shared mantissa multiplier, then one
// bit-serial rounded division per element, results through an output register.
// ----------------------------------------------------------------------------
module rsm_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    job_valid,
   input  rsm_pkg::row_job_type    job,
   output logic                    job_pop,
   output logic [rsm_pkg::IDX_W:0] buf_raddr,
   input  logic [15:0]             buf_rdata,
   output logic [1:0]              bank_busy,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [15:0]             rsp_probability,
   output logic                    rsp_last_of_row,
   output logic                    rsp_tensor_done
);

   localparam int MUL_W = 33;
   localparam int DIVW  = 41;
   localparam int KB    = rsm_pkg::EXP_TABLE_BITS;
   localparam int KW    = $clog2(KB + 2);
   localparam int BITW  = $clog2(DIVW + 1);
   localparam logic [16:0] LOG2E_Q16_EXT = rsm_pkg::LOG2E_Q16;

   rsm_pkg::back_state_type state_ff, state_in;
   rsm_pkg::row_job_type    job_ff, job_in;
   logic [31:0]               ev_mem [rsm_pkg::MAX_ROW];
   logic [rsm_pkg::CNT_W-1:0] idx_ff, idx_in;
   logic [2:0]                ph_ff, ph_in;
   logic [KW-1:0]             kstep_ff, kstep_in;
   logic [KB-1:0]             k_ff, k_in;
   logic [8:0]                n_ff, n_in;
   logic [32:0]               m_ff, m_in;
   logic [65:0]               prod;
   logic [rsm_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic [31:0]               ev_rd_ff;
   logic [DIVW-1:0]           rem_ff, rem_in, quo_ff, quo_in, num;
   logic [BITW-1:0]           dbit_ff, dbit_in;
   logic                      outv_ff, outv_in;
   logic [15:0]               prob_ff, prob_in;
   logic                      lr_ff, lr_in, td_ff, td_in;
   logic [15:0]               diff;
   logic [32:0]               tprod;
   logic [MUL_W-1:0]          fac_tbl [1:KB];
   logic [MUL_W-1:0]          fac;
   logic [31:0]               ev_new;
   logic [DIVW:0]             rem_sh;
   logic                      last_el;
   logic [rsm_pkg::IDX_W-1:0] widx;

   // mantissa factors, one constant per step
   for (genvar g = 1; g <= KB; g++) begin : g_fac
      assign fac_tbl[g] = MUL_W'(rsm_pkg::exp_factor(g));
   end

   assign widx      = idx_ff[rsm_pkg::IDX_W-1:0];
   assign buf_raddr = {job_ff.bank, widx};
   assign job_pop   = (state_ff == rsm_pkg::ST_IDLE) && job_valid;
   assign last_el   = (idx_ff + 1'b1) == job_ff.count;
   assign diff      = job_ff.row_max - buf_rdata;
   assign tprod     = 33'(diff) * 33'(LOG2E_Q16_EXT);
   assign fac       = fac_tbl[kstep_ff];
   assign prod      = 66'(m_ff) * 66'(fac);
   assign ev_new    = ((32'(n_ff) + 32'd16) >= 32'd64) ? 32'd0 : 32'(m_ff >> (7'd16 + 7'(n_ff)));
   assign num       = DIVW'({ev_rd_ff, 16'h0000}) + DIVW'(sum_ff >> 1);
   assign rem_sh    = {rem_ff, quo_ff[DIVW-1]};
   assign rsp_valid = outv_ff;
   assign rsp_probability = prob_ff;
   assign rsp_last_of_row = lr_ff;
   assign rsp_tensor_done = td_ff;

   always_comb begin
      bank_busy = 2'b00;
      if (state_ff != rsm_pkg::ST_IDLE) begin
         bank_busy[job_ff.bank] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == rsm_pkg::ST_EXP && ph_ff == 3'd3) begin
         ev_mem[widx] <= ev_new;
      end
      ev_rd_ff <= ev_mem[widx];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rsm_pkg::ST_IDLE: if (job_valid) state_in = rsm_pkg::ST_EXP;
         rsm_pkg::ST_EXP:  if (ph_ff == 3'd3 && last_el) state_in = rsm_pkg::ST_DIV;
         rsm_pkg::ST_DIV:  if (ph_ff == 3'd2 && dbit_ff == '0) state_in = rsm_pkg::ST_OUT;
         rsm_pkg::ST_OUT: begin
            if (!outv_ff || rsp_ready) begin
               state_in = last_el ? rsm_pkg::ST_IDLE : rsm_pkg::ST_DIV;
            end
         end
         default: state_in = rsm_pkg::ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      job_in = job_ff;   idx_in = idx_ff;   ph_in = ph_ff;
      kstep_in = kstep_ff; k_in = k_ff; n_in = n_ff; m_in = m_ff;
      sum_in = sum_ff; rem_in = rem_ff; quo_in = quo_ff; dbit_in = dbit_ff;
      outv_in = outv_ff && !rsp_ready;
      prob_in = prob_ff; lr_in = lr_ff; td_in = td_ff;
      unique case (state_ff)
         rsm_pkg::ST_IDLE: begin
            if (job_valid) begin
               job_in = job; idx_in = '0; ph_in = 3'd0; sum_in = '0;
            end
         end
         rsm_pkg::ST_EXP: begin
            unique case (ph_ff)
               3'd0: ph_in = 3'd1;
               3'd1: begin
                  n_in = tprod[32:24];
                  k_in = tprod[23 -: KB];
                  m_in = 33'h1_0000_0000;
                  kstep_in = KW'(1);
                  ph_in = 3'd2;
               end
               3'd2: begin
                  if (k_ff[KB - int'(kstep_ff)]) begin
                     m_in = prod[64:32];
                  end
                  if (kstep_ff == KW'(KB)) begin
                     ph_in = 3'd3;
                  end else begin
                     kstep_in = kstep_ff + 1'b1;
                  end
               end
               3'd3: begin
                  sum_in = sum_ff + rsm_pkg::SUM_W'(ev_new);
                  ph_in  = 3'd0;
                  idx_in = last_el ? '0 : idx_ff + 1'b1;
               end
               default: ph_in = 3'd0;
            endcase
         end
         rsm_pkg::ST_DIV: begin
            unique case (ph_ff)
               3'd0: ph_in = 3'd1;
               3'd1: begin
                  quo_in = num; rem_in = '0; dbit_in = BITW'(DIVW); ph_in = 3'd2;
               end
               3'd2: begin
                  if (dbit_ff != '0) begin
                     if (rem_sh >= (DIVW+1)'(sum_ff)) begin
                        rem_in = DIVW'(rem_sh - (DIVW+1)'(sum_ff));
                        quo_in = {quo_ff[DIVW-2:0], 1'b1};
                     end else begin
                        rem_in = rem_sh[DIVW-1:0];
                        quo_in = {quo_ff[DIVW-2:0], 1'b0};
                     end
                     dbit_in = dbit_ff - 1'b1;
                  end
               end
               default: ph_in = 3'd0;
            endcase
         end
         rsm_pkg::ST_OUT: begin
            if (!outv_ff || rsp_ready) begin
               outv_in = 1'b1;
               prob_in = (quo_ff > DIVW'(16'hFFFF)) ? 16'hFFFF : quo_ff[15:0];
               lr_in   = last_el;
               td_in   = last_el && job_ff.tensor_end;
               ph_in   = 3'd0;
               idx_in  = idx_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in; idx_ff <= idx_in; kstep_ff <= kstep_in; k_ff <= k_in;
      n_ff <= n_in; m_ff <= m_in; sum_ff <= sum_in; rem_ff <= rem_in;
      quo_ff <= quo_in; dbit_ff <= dbit_in; prob_ff <= prob_in; lr_ff <= lr_in;
      td_ff <= td_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rsm_pkg::ST_IDLE;
         ph_ff    <= 3'd0;
         outv_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         ph_ff    <= ph_in;
         outv_ff  <= outv_in;
      end
   end

endmodule

### rtl/core/row_softmax_core.sv
// ----------------------------------------------------------------------------
// row_softmax_core
// Softmax over rows of Q8.8 scores, emitting Q0.16 probabilities.
//
//   channel  prefix  dir  payload
//   input    req_    in   score, last_in_tensor
//   result   rsp_    out  probability, last_of_row, tensor_done
//   config   csr_    in   row_length
//
// loading accepts one score per cycle while req_ready is high; the row buffer
// has two banks so the next row loads while the back part works. per element
// the back part uses a serial mantissa multiplier (exp) and a bit-serial divider.
// reset is synchronous; no clearing pass. a stalled rsp side holds the back part.
// ----------------------------------------------------------------------------
module row_softmax_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_score,
   input  logic        req_last_in_tensor,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_probability,
   output logic        rsp_last_of_row,
   output logic        rsp_tensor_done,
   input  logic        csr_write_enable,
   input  logic [6:0]  csr_write_data
);

   logic [rsm_pkg::LEN_W-1:0] row_length_ff;
   logic [15:0]               buf_mem [2*rsm_pkg::MAX_ROW];
   logic                      buf_we;
   logic [rsm_pkg::IDX_W:0]   buf_waddr, buf_raddr;
   logic [15:0]               buf_wdata, buf_rdata_ff;
   logic                      job_push, job_pop, job_full, job_valid;
   rsm_pkg::row_job_type      job_data, job_head;
   logic [1:0]                bank_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff <= rsm_pkg::LEN_W'(rsm_pkg::MAX_ROW);
      end else if (csr_write_enable) begin
         row_length_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (buf_we) begin
         buf_mem[buf_waddr] <= buf_wdata;
      end
      buf_rdata_ff <= buf_mem[buf_raddr];
   end

   rsm_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_score, .req_last_in_tensor,
      .row_length_ff, .job_full, .bank_busy, .buf_we, .buf_waddr, .buf_wdata,
      .job_push, .job_data
   );

   rsm_queue u_queue (
      .clock, .reset, .push(job_push), .push_data(job_data), .full(job_full),
      .pop(job_pop), .not_empty(job_valid), .head(job_head)
   );

   rsm_back u_back (
      .clock, .reset, .job_valid, .job(job_head), .job_pop, .buf_raddr,
      .buf_rdata(buf_rdata_ff), .bank_busy, .rsp_valid, .rsp_ready,
      .rsp_probability, .rsp_last_of_row, .rsp_tensor_done
   );

endmodule

### rtl/core/rsm_checker.sv
// ----------------------------------------------------------------------------
// rsm_checker
// Port-level checks on the row softmax core.
// ----------------------------------------------------------------------------
module rsm_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_probability,
   input logic        rsp_last_of_row,
   input logic        rsp_tensor_done
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_probability))
      else $error("rsp dropped while stalled");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tensor_done |-> rsp_last_of_row)
      else $error("tensor_done without last_of_row");

   a_reset_idle: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind row_softmax_core rsm_checker u_rsm_checker (.*);
